/* rtl/core/positional_list_engine_assert.svh */
// Assertion macros for the positional list engine.
// Included by the module that checks its own behavior; needs nothing else.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("positional list engine check failed");
`define PLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine check failed");
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine check failed");
`else
`define PLE_ASSERT(label, clk, rst, prop)
`define PLE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/plel_pkg.sv */
// Shared types, constants and the double compare for the positional list engine.
// Used by plel_cell and positional_list_engine; depends on nothing.
package plel_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = 5;
   localparam int DATA_W = 64;
   localparam int CMP_W = POS_W + CNT_W;

   localparam logic [DATA_W-2:0] EXP_MASK = 63'h7FF0_0000_0000_0000;

   typedef enum logic [2:0] {
      MODE_INSERT = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_SEARCH = 3'd2,
      MODE_READ   = 3'd3,
      MODE_WRITE  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              do_insert;
      logic              do_delete;
      logic              do_write;
      logic              do_read;
      logic [CMP_W-1:0]  target;
      logic [CMP_W-1:0]  count;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   function automatic logic is_nan(input logic [DATA_W-1:0] x);
      is_nan = x[DATA_W-2:0] > EXP_MASK;
   endfunction

   function automatic logic dbl_equal(input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
      logic both_zero;
      both_zero = (a[DATA_W-2:0] == '0) && (b[DATA_W-2:0] == '0);
      dbl_equal = !is_nan(a) && !is_nan(b) && (both_zero || (a == b));
   endfunction

endpackage

/* rtl/core/plel_cell.sv */
// One storage cell of the list row: holds one word and shifts with its neighbors.
// Depends on plel_pkg.
module plel_cell (
   input  logic                           clock,
   input  plel_pkg::cell_cmd_type         cmd,
   input  logic [plel_pkg::IDX_W-1:0]     cell_index,
   input  logic [plel_pkg::DATA_W-1:0]    left_data,
   input  logic [plel_pkg::DATA_W-1:0]    right_data,
   output logic [plel_pkg::DATA_W-1:0]    data,
   output logic                           match,
   output logic [plel_pkg::DATA_W-1:0]    sel_data
);

   logic [plel_pkg::DATA_W-1:0] data_ff;
   logic [plel_pkg::DATA_W-1:0] data_in;
   logic [plel_pkg::CMP_W-1:0]  my_idx;

   assign my_idx = plel_pkg::CMP_W'(cell_index);

   always_comb begin
      data_in = data_ff;
      if (cmd.do_insert) begin
         if (my_idx > cmd.target) begin
            data_in = left_data;
         end else if (my_idx == cmd.target) begin
            data_in = cmd.value;
         end
      end else if (cmd.do_delete) begin
         if (my_idx >= cmd.target) begin
            data_in = right_data;
         end
      end else if (cmd.do_write && (my_idx == cmd.target)) begin
         data_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign match    = (my_idx < cmd.count) && plel_pkg::dbl_equal(data_ff, cmd.value);
   assign sel_data = (cmd.do_read && (my_idx == cmd.target)) ? data_ff : '0;

endmodule

/* rtl/core/positional_list_engine.sv */
// Channel     Direction  Ports
// req_        in         req_valid, req_stall, req_mode, req_position, req_value
// rsp_        out        rsp_valid, rsp_stall, rsp_status, rsp_found_position,
//                        rsp_read_data, rsp_entry_total
// One word is accepted per cycle while req_stall is low, and its result is registered in the output register.
// The row of cells shifts, writes and compares all entries together, for the word being accepted.
// Reset clears the entry count and the output valid; entries hold nothing until inserted.
// req_stall is high only while a result waits in the output register under rsp_stall.
// Top level of the positional list engine; depends on plel_pkg, plel_cell and the
// assertion header.
`include "positional_list_engine_assert.svh"

module positional_list_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_mode,
   input  logic [plel_pkg::POS_W-1:0]     req_position,
   input  logic [plel_pkg::DATA_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [plel_pkg::POS_W-1:0]     rsp_found_position,
   output logic [plel_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [plel_pkg::POS_W-1:0]     rsp_entry_total
);

   logic                          accept;
   logic [plel_pkg::CNT_W-1:0]    count_ff;
   logic [plel_pkg::CNT_W-1:0]    count_in;
   logic [plel_pkg::CMP_W-1:0]    pos_ext;
   logic [plel_pkg::CMP_W-1:0]    cnt_ext;
   logic                          valid_pos;
   plel_pkg::status_type          status_in;
   logic                          op_insert;
   logic                          op_delete;
   logic                          op_write;
   logic                          op_read;
   logic                          op_search;
   plel_pkg::cell_cmd_type        cmd;
   logic [plel_pkg::DATA_W-1:0]   cell_data [plel_pkg::CAPACITY];
   logic [plel_pkg::DATA_W-1:0]   cell_sel  [plel_pkg::CAPACITY];
   logic [plel_pkg::CAPACITY-1:0] cell_match;
   logic [plel_pkg::POS_W-1:0]    found_in;
   logic [plel_pkg::DATA_W-1:0]   rdata_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   plel_pkg::status_type          rsp_status_ff;
   logic [plel_pkg::POS_W-1:0]    rsp_found_ff;
   logic [plel_pkg::DATA_W-1:0]   rsp_rdata_ff;
   logic [plel_pkg::POS_W-1:0]    rsp_total_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext   = plel_pkg::CMP_W'(req_position);
   assign cnt_ext   = plel_pkg::CMP_W'(count_ff);
   assign valid_pos = (pos_ext != '0) && (pos_ext <= cnt_ext);

   always_comb begin
      status_in = plel_pkg::ST_OK;
      op_insert = 1'b0;
      op_delete = 1'b0;
      op_write  = 1'b0;
      op_read   = 1'b0;
      op_search = 1'b0;
      count_in  = count_ff;
      case (plel_pkg::mode_type'(req_mode))
         plel_pkg::MODE_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = plel_pkg::ST_RANGE;
            end else if (count_ff == plel_pkg::CNT_W'(plel_pkg::CAPACITY)) begin
               status_in = plel_pkg::ST_FULL;
            end else begin
               op_insert = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         plel_pkg::MODE_DELETE: begin
            if (!valid_pos) begin
               status_in = plel_pkg::ST_RANGE;
            end else begin
               op_delete = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         plel_pkg::MODE_SEARCH: begin
            op_search = 1'b1;
         end
         plel_pkg::MODE_READ: begin
            if (!valid_pos) begin
               status_in = plel_pkg::ST_RANGE;
            end else begin
               op_read = 1'b1;
            end
         end
         plel_pkg::MODE_WRITE: begin
            if (!valid_pos) begin
               status_in = plel_pkg::ST_RANGE;
            end else begin
               op_write = 1'b1;
            end
         end
         default: begin
            status_in = plel_pkg::ST_RANGE;
         end
      endcase
   end

   // Insert targets the slot after the position; the others target the position itself.
   always_comb begin
      cmd.do_insert = accept && op_insert;
      cmd.do_delete = accept && op_delete;
      cmd.do_write  = accept && op_write;
      cmd.do_read   = op_read;
      cmd.target    = op_insert ? pos_ext : (pos_ext - 1'b1);
      cmd.count     = cnt_ext;
      cmd.value     = req_value;
   end

   for (genvar g = 0; g < plel_pkg::CAPACITY; g++) begin : g_cell
      logic [plel_pkg::DATA_W-1:0] left_word;
      logic [plel_pkg::DATA_W-1:0] right_word;

      if (g == 0) begin : g_head
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = cell_data[g-1];
      end

      if (g == plel_pkg::CAPACITY - 1) begin : g_tail
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_data[g+1];
      end

      plel_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (plel_pkg::IDX_W'(g)),
         .left_data  (left_word),
         .right_data (right_word),
         .data       (cell_data[g]),
         .match      (cell_match[g]),
         .sel_data   (cell_sel[g])
      );
   end

   // The lowest matching cell wins.
   always_comb begin
      found_in = '0;
      rdata_in = '0;
      for (int i = plel_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (op_search && cell_match[i]) begin
            found_in = plel_pkg::POS_W'(i + 1);
         end
      end
      for (int i = 0; i < plel_pkg::CAPACITY; i++) begin
         rdata_in = rdata_in | cell_sel[i];
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_rdata_ff  <= rdata_in;
         rsp_total_ff  <= plel_pkg::POS_W'(count_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_read_data      = rsp_rdata_ff;
   assign rsp_entry_total    = rsp_total_ff;

   `PLE_ASSERT(a_count_bound, clock, reset, count_ff <= plel_pkg::CNT_W'(plel_pkg::CAPACITY))
   `PLE_ASSERT_IMPL(a_total_tracks, clock, reset, rsp_valid_ff, rsp_total_ff == plel_pkg::POS_W'(count_ff))
   `PLE_ASSERT_NEXT(a_error_no_change, clock, reset, accept && (status_in != plel_pkg::ST_OK), $stable(count_ff))
   `PLE_ASSERT_IMPL(a_found_in_list, clock, reset, rsp_valid_ff, rsp_found_ff <= rsp_total_ff)
   `PLE_ASSERT_NEXT(a_read_zero_on_error, clock, reset, accept && (status_in != plel_pkg::ST_OK), rsp_rdata_ff == '0)

endmodule

/* dv/positional_list_engine_checker.sv */
`timescale 1ns / 100ps
// Checker for the positional list engine: keeps its own copy of the list, predicts
// one result per accepted request word and compares every accepted response word.
// Depends on plel_pkg for widths, modes and status codes.
module positional_list_engine_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [2:0]                  req_mode,
   input  logic [plel_pkg::POS_W-1:0]  req_position,
   input  logic [plel_pkg::DATA_W-1:0] req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [1:0]                  rsp_status,
   input  logic [plel_pkg::POS_W-1:0]  rsp_found_position,
   input  logic [plel_pkg::DATA_W-1:0] rsp_read_data,
   input  logic [plel_pkg::POS_W-1:0]  rsp_entry_total,
   output int                          fail_count,
   output int                          pending,
   output int                          list_size
);

   typedef struct packed {
      logic [1:0]                  status;
      logic [plel_pkg::POS_W-1:0]  found;
      logic [plel_pkg::DATA_W-1:0] data;
      logic [plel_pkg::POS_W-1:0]  total;
   } outcome_type;

   logic [plel_pkg::DATA_W-1:0] cells [plel_pkg::CAPACITY];
   int used = 0;
   int errors = 0;
   outcome_type awaited [$];

   assign fail_count = errors;

   function automatic bit nan_bits(input logic [plel_pkg::DATA_W-1:0] x);
      return (&x[62:52]) && (|x[51:0]);
   endfunction

   function automatic bit doubles_match(input logic [plel_pkg::DATA_W-1:0] a,
                                        input logic [plel_pkg::DATA_W-1:0] b);
      if (nan_bits(a) || nan_bits(b)) begin
         return 1'b0;
      end
      return ((a[62:0] == '0) && (b[62:0] == '0)) || (a == b);
   endfunction

   function automatic outcome_type step_list(input logic [2:0]                  mode,
                                             input logic [plel_pkg::POS_W-1:0]  pos,
                                             input logic [plel_pkg::DATA_W-1:0] val);
      outcome_type res;
      bit in_list;
      res = '0;
      res.status = plel_pkg::ST_OK;
      in_list = (pos >= 1) && (pos <= used);
      case (mode)
         plel_pkg::MODE_INSERT: begin
            if (pos > used) begin
               res.status = plel_pkg::ST_RANGE;
            end else if (used >= plel_pkg::CAPACITY) begin
               res.status = plel_pkg::ST_FULL;
            end else begin
               for (int i = plel_pkg::CAPACITY - 1; i > 0; i--) begin
                  if (i > pos && i <= used) begin
                     cells[i] = cells[i-1];
                  end
               end
               cells[pos] = val;
               used++;
            end
         end
         plel_pkg::MODE_DELETE: begin
            if (!in_list) begin
               res.status = plel_pkg::ST_RANGE;
            end else begin
               for (int i = 0; i < plel_pkg::CAPACITY - 1; i++) begin
                  if (i >= pos - 1 && i + 1 < used) begin
                     cells[i] = cells[i+1];
                  end
               end
               used--;
            end
         end
         plel_pkg::MODE_SEARCH: begin
            for (int i = 0; i < plel_pkg::CAPACITY; i++) begin
               if (i < used && res.found == '0 && doubles_match(cells[i], val)) begin
                  res.found = plel_pkg::POS_W'(i + 1);
               end
            end
         end
         plel_pkg::MODE_READ: begin
            if (!in_list) begin
               res.status = plel_pkg::ST_RANGE;
            end else begin
               res.data = cells[pos-1];
            end
         end
         plel_pkg::MODE_WRITE: begin
            if (!in_list) begin
               res.status = plel_pkg::ST_RANGE;
            end else begin
               cells[pos-1] = val;
            end
         end
         default: begin
            res.status = plel_pkg::ST_RANGE;
         end
      endcase
      res.total = plel_pkg::POS_W'(used);
      return res;
   endfunction

   task automatic flag(input string field, input logic [plel_pkg::DATA_W-1:0] got,
                       input logic [plel_pkg::DATA_W-1:0] want);
      errors++;
      $display("mismatch in %s at %0t: got %h, expected %h", field, $time, got, want);
   endtask

   always @(posedge clock) begin : watch
      outcome_type due;
      if (reset) begin
         used = 0;
         awaited.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               flag("unexpected word", rsp_read_data, '0);
            end else begin
               due = awaited.pop_front();
               if (rsp_status !== due.status) begin
                  flag("status", plel_pkg::DATA_W'(rsp_status),
                       plel_pkg::DATA_W'(due.status));
               end
               if (rsp_found_position !== due.found) begin
                  flag("found_position", plel_pkg::DATA_W'(rsp_found_position),
                       plel_pkg::DATA_W'(due.found));
               end
               if (rsp_read_data !== due.data) begin
                  flag("read_data", rsp_read_data, due.data);
               end
               if (rsp_entry_total !== due.total) begin
                  flag("entry_total", plel_pkg::DATA_W'(rsp_entry_total),
                       plel_pkg::DATA_W'(due.total));
               end
            end
         end
         if (req_valid && !req_stall) begin
            awaited.push_back(step_list(req_mode, req_position, req_value));
         end
      end
      pending <= awaited.size();
      list_size <= used;
   end

endmodule

/* dv/positional_list_engine_test.sv */
`timescale 1ns / 100ps
// Top of the positional list engine testbench: clock, reset, request and response
// stimulus with random gaps, and the verdict. Depends on plel_pkg, the engine and
// positional_list_engine_checker.
module positional_list_engine_test;

   localparam int WORDS = 1900;
   localparam int TAIL_WORDS = 200;
   localparam int PRESSURE_AT = 700;
   localparam int PRESSURE_CYCLES = 40;

   localparam logic [plel_pkg::DATA_W-1:0] PLUS_ZERO  = 64'h0000_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] MINUS_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] PLUS_INF   = 64'h7FF0_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] MINUS_INF  = 64'hFFF0_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] LOW_NAN    = 64'h7FF0_0000_0000_0001;
   localparam logic [plel_pkg::DATA_W-1:0] QUIET_NAN  = 64'hFFF8_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [plel_pkg::DATA_W-1:0] PLUS_ONE   = 64'h3FF0_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] MINUS_ONE  = 64'hBFF0_0000_0000_0000;
   localparam logic [plel_pkg::DATA_W-1:0] PLUS_TINY  = 64'h0000_0000_0000_0001;
   localparam logic [plel_pkg::DATA_W-1:0] MINUS_TINY = 64'h8000_0000_0000_0001;

   localparam logic [plel_pkg::DATA_W-1:0] VALUE_POOL [11] = '{PLUS_ZERO, MINUS_ZERO,
      PLUS_INF, MINUS_INF, LOW_NAN, QUIET_NAN, ALL_ONES, PLUS_ONE, MINUS_ONE, PLUS_TINY,
      MINUS_TINY};

   localparam logic [2:0] MODE_RESERVED [3] = '{3'd5, 3'd6, 3'd7};

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [2:0]                  req_mode;
   logic [plel_pkg::POS_W-1:0]  req_position;
   logic [plel_pkg::DATA_W-1:0] req_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [1:0]                  rsp_status;
   logic [plel_pkg::POS_W-1:0]  rsp_found_position;
   logic [plel_pkg::DATA_W-1:0] rsp_read_data;
   logic [plel_pkg::POS_W-1:0]  rsp_entry_total;

   int fail_count;
   int pending;
   int list_size;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   positional_list_engine u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_data      (rsp_read_data),
      .rsp_entry_total    (rsp_entry_total)
   );

   positional_list_engine_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_data      (rsp_read_data),
      .rsp_entry_total    (rsp_entry_total),
      .fail_count         (fail_count),
      .pending            (pending),
      .list_size          (list_size)
   );

   task automatic send_word(input logic [2:0] mode, input logic [plel_pkg::POS_W-1:0] pos,
                            input logic [plel_pkg::DATA_W-1:0] val);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_position <= pos;
      req_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic random_word(input bit filling);
      int roll;
      logic [2:0] mode;
      logic [plel_pkg::POS_W-1:0] pos;
      logic [plel_pkg::DATA_W-1:0] val;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         mode = MODE_RESERVED[$urandom_range(0, 2)];
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 75 : 15)) begin
            mode = plel_pkg::MODE_INSERT;
         end else if (roll < (filling ? 80 : 65)) begin
            mode = plel_pkg::MODE_DELETE;
         end else if (roll < (filling ? 90 : 80)) begin
            mode = plel_pkg::MODE_SEARCH;
         end else if (roll < (filling ? 95 : 90)) begin
            mode = plel_pkg::MODE_READ;
         end else begin
            mode = plel_pkg::MODE_WRITE;
         end
      end
      if ($urandom_range(0, 99) < 8) begin
         pos = plel_pkg::POS_W'($urandom_range(0, 31));
      end else if (mode == plel_pkg::MODE_INSERT) begin
         pos = plel_pkg::POS_W'($urandom_range(0, list_size));
      end else begin
         pos = plel_pkg::POS_W'($urandom_range(1, (list_size > 0) ? list_size : 1));
      end
      if ($urandom_range(0, 9) < 7) begin
         val = VALUE_POOL[$urandom_range(0, 10)];
      end else begin
         val = {$urandom(), $urandom()};
      end
      send_word(mode, pos, val);
   endtask

   initial begin : receiver
      int stretch;
      int stall_odds;
      bit pressure_done;
      stretch = 0;
      stall_odds = 0;
      pressure_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (stretch == 0) begin
            stretch = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 10;
               default: stall_odds = 40;
            endcase
         end
         stretch--;
         if (hold_off && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < stall_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int sent;
      int episode_left;
      int free_run;
      int idle_odds;
      bit filling;
      episode_left = 0;
      free_run = 0;
      idle_odds = 0;
      filling = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= plel_pkg::MODE_SEARCH;
      req_position <= '0;
      req_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(plel_pkg::MODE_SEARCH, 5'd0, PLUS_ZERO);
      send_word(plel_pkg::MODE_READ, 5'd0, PLUS_ZERO);
      send_word(plel_pkg::MODE_DELETE, 5'd1, PLUS_ZERO);
      send_word(plel_pkg::MODE_INSERT, 5'd1, PLUS_ONE);
      foreach (MODE_RESERVED[i]) begin
         send_word(MODE_RESERVED[i], 5'd0, PLUS_ZERO);
      end
      send_word(plel_pkg::MODE_INSERT, 5'd0, PLUS_ZERO);
      send_word(plel_pkg::MODE_INSERT, 5'd1, QUIET_NAN);
      send_word(plel_pkg::MODE_INSERT, 5'd2, MINUS_ZERO);
      send_word(plel_pkg::MODE_INSERT, 5'd0, PLUS_INF);
      send_word(plel_pkg::MODE_SEARCH, 5'd0, MINUS_ZERO);
      send_word(plel_pkg::MODE_SEARCH, 5'd0, QUIET_NAN);
      send_word(plel_pkg::MODE_SEARCH, 5'd0, PLUS_INF);
      send_word(plel_pkg::MODE_SEARCH, 5'd0, PLUS_ONE);
      send_word(plel_pkg::MODE_READ, 5'd4, PLUS_ZERO);
      send_word(plel_pkg::MODE_READ, 5'd5, PLUS_ZERO);
      send_word(plel_pkg::MODE_WRITE, 5'd0, PLUS_ONE);
      send_word(plel_pkg::MODE_WRITE, 5'd1, ALL_ONES);
      send_word(plel_pkg::MODE_READ, 5'd1, PLUS_ZERO);
      send_word(plel_pkg::MODE_DELETE, 5'd31, PLUS_ZERO);
      send_word(plel_pkg::MODE_DELETE, 5'd2, PLUS_ZERO);

      for (sent = 0; sent < WORDS; sent++) begin
         if (episode_left == 0) begin
            filling = !filling;
            episode_left = $urandom_range(24, 40);
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 12;
               default: idle_odds = 50;
            endcase
         end
         episode_left--;
         if (sent == PRESSURE_AT) begin
            hold_off = 1'b1;
            free_run = 60;
         end
         if (sent == WORDS - TAIL_WORDS) begin
            quiet = 1'b1;
         end
         random_word(filling);
         if (free_run > 0) begin
            free_run--;
         end else if (!quiet && $urandom_range(0, 99) < idle_odds) begin
            pause_sender($urandom_range(1, 15));
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("positional_list_engine_test OK");
      end else begin
         $display("positional_list_engine_test NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("positional_list_engine_test NOT OK");
      $finish;
   end

endmodule
